// ===== sv/buddy_block_allocator_macros.svh =====
// Assertion macros shared by the buddy allocator's checker.
// No dependencies; take it in by include inside a module that has clk and arst_n.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// Shared types, codes and helpers of the buddy block allocator.
// No dependencies; the top level, sequencer, datapath and checker import it.
`timescale 1ns / 1ps

package bba_pkg;

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  size_units;
		logic [19:0] unit_index;
		logic [3:0]  seed_order;
		logic [15:0] owner_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] unit_out;
		logic [15:0] owner_out;
		logic [10:0] free_units;
	} rsp_t;

	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE  = 2'd1;
	localparam logic [1:0] FN_QUERY = 2'd2;
	localparam logic [1:0] FN_SEED  = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic REG_TOP_ORDER = 1'b0;
	localparam logic REG_BASE      = 1'b1;

	localparam int ORD_W = 5;
	localparam int SUM_W = 18;
	localparam logic [10:0] CNT_MAX = 11'h7ff;

	// Sequencer steps; the controller state and the datapath command share them.
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_CLR   = 5'd0;
	localparam logic [OP_W-1:0] OP_IDLE  = 5'd1;
	localparam logic [OP_W-1:0] OP_RD_R  = 5'd2;
	localparam logic [OP_W-1:0] OP_CHK   = 5'd3;
	localparam logic [OP_W-1:0] OP_MERGE = 5'd4;
	localparam logic [OP_W-1:0] OP_BUD   = 5'd5;
	localparam logic [OP_W-1:0] OP_UL1   = 5'd6;
	localparam logic [OP_W-1:0] OP_UL2   = 5'd7;
	localparam logic [OP_W-1:0] OP_UL3   = 5'd8;
	localparam logic [OP_W-1:0] OP_UL4   = 5'd9;
	localparam logic [OP_W-1:0] OP_JOIN  = 5'd10;
	localparam logic [OP_W-1:0] OP_PUSH  = 5'd11;
	localparam logic [OP_W-1:0] OP_PH1   = 5'd12;
	localparam logic [OP_W-1:0] OP_PH2   = 5'd13;
	localparam logic [OP_W-1:0] OP_SRCH  = 5'd14;
	localparam logic [OP_W-1:0] OP_TAKE  = 5'd15;
	localparam logic [OP_W-1:0] OP_AFIX1 = 5'd16;
	localparam logic [OP_W-1:0] OP_AFIX2 = 5'd17;
	localparam logic [OP_W-1:0] OP_SPL   = 5'd18;
	localparam logic [OP_W-1:0] OP_SPW   = 5'd19;
	localparam logic [OP_W-1:0] OP_FIN   = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            take;
		logic            load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic is_query;
		logic bad;
		logic blk_free;
		logic merge_stop;
		logic bud_match;
		logic pv_nz;
		logic nx_nz;
		logic hd_nz;
		logic rd_nxt_nz;
		logic nofit;
		logic split_more;
		logic p_ok;
	} flg_t;

	// Smallest order whose block holds the request; a size of zero counts as one.
	function automatic logic [ORD_W-1:0] size_order(input logic [9:0] s);
		logic [10:0]      sz;
		logic [ORD_W-1:0] k;
		sz = (s == 10'd0) ? 11'd1 : {1'b0, s};
		k = 5'd10;
		for (int i = 10; i >= 0; i--) begin
			if ((11'd1 << i) >= sz) k = ORD_W'(i);
		end
		return k;
	endfunction

endpackage

// ===== sv/buddy_block_allocator.sv =====
// Buddy block allocator top level: configuration registers, sequencer and datapath.
// Depends on bba_pkg, bba_ctrl, bba_dpath and bba_ram.
// After reset the unit memory is cleared one unit a cycle, every unit, before any request.
// A query's result is loaded in the finish step, after the read and check steps; allocate runs
// split steps per split round and free or seed runs merge, unlink and join steps per merge round.
// One request is in work at a time; a finished result waits in its own register.
`timescale 1ns / 1ps

module buddy_block_allocator #(
	parameter int UNITS    = 1024,
	parameter int ORDERS   = 10,
	parameter int TAG_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          req_valid,
	output logic          req_ready,
	input  bba_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bba_pkg::rsp_t rsp
);
	import bba_pkg::*;

	logic [3:0]  top_order_q;
	logic [19:0] base_q;
	logic        cfg_wr;
	cmd_t        cmd;
	flg_t        flg;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_BASE) ? {12'd0, base_q} : {28'd0, top_order_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_order_q <= 4'd9;
			base_q      <= 20'd1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TOP_ORDER) top_order_q <= pwdata[3:0];
			else base_q <= pwdata[19:0];
		end
	end

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.flg       (flg),
		.cmd       (cmd)
	);

	bba_dpath #(.UNITS(UNITS), .ORDERS(ORDERS), .TAG_BITS(TAG_BITS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.flg       (flg),
		.req       (req),
		.top_order (top_order_q),
		.base      (base_q),
		.rsp       (rsp)
	);

endmodule

// ===== sv/bba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== sv/bba_ctrl.sv =====
// Sequencer of the buddy allocator: steps through each request and drives the datapath.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  bba_pkg::flg_t flg,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	logic [OP_W-1:0] state_q, state_d;
	logic            rsp_valid_q;
	logic            can_load;

	assign can_load  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == OP_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign cmd.op    = state_q;
	assign cmd.take  = req_ready && req_valid;
	assign cmd.load  = (state_q == OP_FIN) && can_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			OP_CLR:   if (flg.clr_last) state_d = OP_IDLE;
			OP_IDLE:  if (cmd.take) state_d = flg.is_alloc ? OP_SRCH : OP_RD_R;
			OP_RD_R:  state_d = flg.bad ? OP_FIN : OP_CHK;
			OP_CHK:   state_d = (flg.is_query || flg.blk_free) ? OP_FIN : OP_MERGE;
			OP_MERGE: state_d = flg.merge_stop ? OP_PUSH : OP_BUD;
			OP_BUD:   state_d = flg.bud_match ? OP_UL1 : OP_PUSH;
			OP_UL1:   state_d = flg.pv_nz ? OP_UL2 : OP_UL3;
			OP_UL2:   state_d = OP_UL3;
			OP_UL3:   state_d = flg.nx_nz ? OP_UL4 : OP_JOIN;
			OP_UL4:   state_d = OP_JOIN;
			OP_JOIN:  state_d = OP_MERGE;
			OP_PUSH:  state_d = flg.hd_nz ? OP_PH1 : OP_FIN;
			OP_PH1:   state_d = OP_PH2;
			OP_PH2:   state_d = flg.is_alloc ? OP_SPL : OP_FIN;
			OP_SRCH: begin
				if (flg.nofit) state_d = OP_FIN;
				else if (flg.hd_nz) state_d = OP_TAKE;
			end
			OP_TAKE:  state_d = flg.rd_nxt_nz ? OP_AFIX1 : OP_SPL;
			OP_AFIX1: state_d = OP_AFIX2;
			OP_AFIX2: state_d = OP_SPL;
			OP_SPL: begin
				if (!flg.split_more) state_d = OP_FIN;
				else if (flg.p_ok) state_d = OP_SPW;
			end
			OP_SPW:   state_d = flg.hd_nz ? OP_PH1 : OP_SPL;
			OP_FIN:   if (can_load) state_d = OP_IDLE;
			default:  state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= OP_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/bba_dpath.sv =====
// Datapath of the buddy allocator: unit memory, list heads, free count and result register.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps

module bba_dpath #(
	parameter int UNITS    = 1024,
	parameter int ORDERS   = 10,
	parameter int TAG_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::cmd_t cmd,
	output bba_pkg::flg_t flg,
	input  bba_pkg::req_t req,
	input  logic [3:0]    top_order,
	input  logic [19:0]   base,
	output bba_pkg::rsp_t rsp
);
	import bba_pkg::*;

	localparam int PW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int LW = $clog2(UNITS + 1);
	localparam int OW = (ORDERS > 1) ? $clog2(ORDERS) : 1;
	localparam int WW = 1 + OW + 2 * LW + TAG_BITS;
	localparam logic [SUM_W-1:0] UNITS_S  = SUM_W'(UNITS);
	localparam logic [19:0]      UNITS_U  = 20'(UNITS);
	localparam logic [PW-1:0]    LAST_POS = PW'(UNITS - 1);
	localparam logic [ORD_W-1:0] ORDERS_O = ORD_W'(ORDERS);

	typedef struct packed {
		logic                free;
		logic [OW-1:0]       ord;
		logic [LW-1:0]       nxt;
		logic [LW-1:0]       prv;
		logic [TAG_BITS-1:0] tag;
	} word_t;

	req_t                req_q;
	logic                ok_q;
	logic [PW-1:0]       r_q, sp_q, clr_q;
	logic [ORD_W-1:0]    k_q, j_q;
	word_t               cw_q, bw_q;
	logic [LW-1:0]       nx_q;
	logic [SUM_W-1:0]    add_q;
	logic [1:0]          status_q;
	logic [19:0]         unit_out_q;
	logic [15:0]         owner_out_q;
	logic [10:0]         fc_q;
	logic [LW-1:0]       head_q [ORDERS];
	rsp_t                rsp_q;

	logic                we, re;
	logic [PW-1:0]       waddr, raddr;
	logic [WW-1:0]       rdata;
	word_t               rd_w, wd;

	logic [ORD_W-1:0]    top_eff, cw_ord, jm1, hsel, k_new;
	logic [19:0]         diff;
	logic                idx_ok, hsel_ok, over;
	logic [SUM_W-1:0]    bud_w, p_w, r_s, sum_w, kv, sub_w;
	logic [LW-1:0]       hd, pv_m1, nx_m1, nxq_m1, hd_m1, sp_p1, r_p1;
	logic [OW-1:0]       ordsel;
	logic [ORD_W-1:0]    ordsel5;

	assign rd_w    = word_t'(rdata);
	assign top_eff = (ORD_W'(top_order) > ORDERS_O - 5'd1) ? ORDERS_O - 5'd1 : ORD_W'(top_order);
	assign diff    = req.unit_index - base;
	assign idx_ok  = (req.unit_index != 20'd0) && (req.unit_index >= base) && (diff < UNITS_U);
	assign k_new   = size_order(req.size_units);
	assign cw_ord  = ORD_W'(cw_q.ord);
	assign r_s     = SUM_W'(r_q);
	assign bud_w   = r_s ^ (SUM_W'(1) << cw_ord);
	assign jm1     = j_q - 5'd1;
	assign p_w     = r_s + (SUM_W'(1) << jm1);
	assign over    = (r_s + (SUM_W'(1) << req_q.seed_order)) > UNITS_S;
	assign hsel    = (cmd.op == OP_PUSH) ? cw_ord : j_q;
	assign hsel_ok = hsel < ORDERS_O;
	assign hd      = hsel_ok ? head_q[hsel[OW-1:0]] : '0;
	assign pv_m1   = bw_q.prv - LW'(1);
	assign nx_m1   = bw_q.nxt - LW'(1);
	assign nxq_m1  = nx_q - LW'(1);
	assign hd_m1   = hd - LW'(1);
	assign sp_p1   = LW'(sp_q) + LW'(1);
	assign r_p1    = LW'(r_q) + LW'(1);
	assign ordsel  = (req_q.func == FN_SEED) ? OW'(req_q.seed_order) : rd_w.ord;
	assign ordsel5 = ORD_W'(ordsel);
	assign sum_w   = SUM_W'(fc_q) + add_q;
	assign kv      = SUM_W'(1) << k_q;
	assign sub_w   = SUM_W'(fc_q) - kv;

	assign flg.clr_last   = (clr_q == LAST_POS);
	// While idle the incoming request decides the branch; later the held one does.
	assign flg.is_alloc   = (cmd.op == OP_IDLE) ? (req.func == FN_ALLOC) : (req_q.func == FN_ALLOC);
	assign flg.is_query   = (req_q.func == FN_QUERY);
	assign flg.bad        = !ok_q || ((req_q.func == FN_SEED) &&
	                        ((ORD_W'(req_q.seed_order) >= ORDERS_O) || over));
	assign flg.blk_free   = rd_w.free;
	assign flg.merge_stop = (cw_ord >= top_eff) || (bud_w >= UNITS_S);
	assign flg.bud_match  = rd_w.free && (rd_w.ord == cw_q.ord);
	assign flg.pv_nz      = (bw_q.prv != '0);
	assign flg.nx_nz      = (bw_q.nxt != '0);
	assign flg.hd_nz      = (hd != '0);
	assign flg.rd_nxt_nz  = (rd_w.nxt != '0);
	assign flg.nofit      = (j_q > top_eff);
	assign flg.split_more = (j_q > k_q);
	assign flg.p_ok       = (p_w < UNITS_S);

	// Memory port control: each step does at most one read or one write, never both.
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = r_q;
		raddr = r_q;
		wd    = rd_w;
		case (cmd.op)
			OP_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wd    = '0;
			end
			OP_RD_R:  re = 1'b1;
			OP_MERGE: begin
				re    = 1'b1;
				raddr = bud_w[PW-1:0];
			end
			OP_UL1: begin
				re    = flg.pv_nz;
				raddr = pv_m1[PW-1:0];
			end
			OP_UL2: begin
				we     = 1'b1;
				waddr  = pv_m1[PW-1:0];
				wd.nxt = bw_q.nxt;
			end
			OP_UL3: begin
				re    = flg.nx_nz;
				raddr = nx_m1[PW-1:0];
			end
			OP_UL4: begin
				we     = 1'b1;
				waddr  = nx_m1[PW-1:0];
				wd.prv = bw_q.prv;
			end
			OP_JOIN: begin
				we = 1'b1;
				if (bud_w < r_s) begin
					waddr = r_q;
					wd    = cw_q;
				end else begin
					waddr = bud_w[PW-1:0];
					wd    = bw_q;
					wd.free = 1'b0;
					wd.nxt  = '0;
					wd.prv  = '0;
				end
			end
			OP_PUSH: begin
				we = 1'b1;
				wd = '0;
				wd.free = 1'b1;
				wd.ord  = cw_q.ord;
				wd.nxt  = hd;
			end
			OP_PH1, OP_AFIX1: begin
				re    = 1'b1;
				raddr = nxq_m1[PW-1:0];
			end
			OP_PH2: begin
				we     = 1'b1;
				waddr  = nxq_m1[PW-1:0];
				wd.prv = sp_p1;
			end
			OP_AFIX2: begin
				we     = 1'b1;
				waddr  = nxq_m1[PW-1:0];
				wd.prv = '0;
			end
			OP_SRCH: begin
				re    = 1'b1;
				raddr = hd_m1[PW-1:0];
			end
			OP_TAKE: begin
				we = 1'b1;
				wd = '0;
				wd.ord = k_q[OW-1:0];
				wd.tag = TAG_BITS'(req_q.owner_in);
			end
			OP_SPL: begin
				re    = 1'b1;
				raddr = p_w[PW-1:0];
			end
			OP_SPW: begin
				we      = 1'b1;
				waddr   = sp_q;
				wd.free = 1'b1;
				wd.ord  = j_q[OW-1:0];
				wd.nxt  = hd;
				wd.prv  = '0;
			end
			default: ;
		endcase
	end

	bba_ram #(.WIDTH(WW), .DEPTH(UNITS)) u_units (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wd),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= '0;
			clr_q  <= '0;
			head_q <= '{default: '0};
		end else begin
			case (cmd.op)
				OP_CLR: clr_q <= clr_q + PW'(1);
				OP_UL1: begin
					if (!flg.pv_nz && (ORD_W'(bw_q.ord) < ORDERS_O)) head_q[bw_q.ord] <= bw_q.nxt;
				end
				OP_PUSH: begin
					if (hsel_ok) head_q[hsel[OW-1:0]] <= r_p1;
					fc_q <= (sum_w > SUM_W'(CNT_MAX)) ? CNT_MAX : sum_w[10:0];
				end
				OP_TAKE: head_q[j_q[OW-1:0]] <= rd_w.nxt;
				OP_SPW:  head_q[j_q[OW-1:0]] <= sp_p1;
				OP_SPL: begin
					if (!flg.split_more) fc_q <= (SUM_W'(fc_q) >= kv) ? sub_w[10:0] : 11'd0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q       <= req;
			ok_q        <= idx_ok;
			r_q         <= idx_ok ? diff[PW-1:0] : '0;
			k_q         <= k_new;
			j_q         <= k_new;
			status_q    <= ST_DONE;
			unit_out_q  <= '0;
			owner_out_q <= '0;
		end
		case (cmd.op)
			OP_RD_R: if (flg.bad) status_q <= ST_IGNORED;
			OP_CHK: begin
				if (flg.is_query) begin
					owner_out_q <= 16'(rd_w.tag);
				end else if (rd_w.free) begin
					status_q <= ST_IGNORED;
				end else begin
					cw_q  <= '{free: rd_w.free, ord: ordsel, nxt: rd_w.nxt, prv: rd_w.prv,
					           tag: '0};
					add_q <= SUM_W'(1) << ordsel5[3:0];
				end
			end
			OP_BUD: bw_q <= rd_w;
			OP_JOIN: begin
				// The lower half of the pair becomes the head of the merged block.
				if (bud_w < r_s) begin
					r_q  <= bud_w[PW-1:0];
					cw_q <= '{free: 1'b0, ord: cw_q.ord + OW'(1), nxt: '0, prv: '0, tag: '0};
				end else begin
					cw_q.ord <= cw_q.ord + OW'(1);
				end
			end
			OP_PUSH: begin
				nx_q <= hd;
				sp_q <= r_q;
			end
			OP_SRCH: begin
				if (flg.nofit) status_q <= ST_NOFIT;
				else if (flg.hd_nz) r_q <= hd_m1[PW-1:0];
				else j_q <= j_q + 5'd1;
			end
			OP_TAKE: nx_q <= rd_w.nxt;
			OP_SPL: begin
				if (flg.split_more) begin
					j_q  <= jm1;
					sp_q <= p_w[PW-1:0];
				end else begin
					unit_out_q <= base + 20'(r_q);
				end
			end
			OP_SPW: nx_q <= hd;
			default: ;
		endcase
		if (cmd.load) rsp_q <= '{status: status_q, unit_out: unit_out_q,
		                         owner_out: owner_out_q, free_units: fc_q};
	end

	assign rsp = rsp_q;

endmodule

// ===== sv/bba_checker.sv =====
// Port-level checks on the buddy allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_macros.svh.
`timescale 1ns / 1ps

module bba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bba_pkg::rsp_t rsp
);
	import bba_pkg::*;
	`include "buddy_block_allocator_macros.svh"

	`BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
	`BBA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second request taken while one is in work")
	`BBA_ASSERT_NOW(a_unit_only_done, rsp_valid && rsp.status != ST_DONE, rsp.unit_out == 20'd0, "unit given with a failing status")
	`BBA_ASSERT_NOW(a_owner_only_done, rsp_valid && rsp.owner_out != 16'd0, rsp.status == ST_DONE, "owner tag given with a failing status")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
